// ===== rtl/core/rpd_pkg.sv =====
`default_nettype none

package rpd_pkg;

    // Field widths fixed by the stream formats.
    localparam int WORD_W     = 31;
    localparam int ELEM_W     = 10;
    localparam int CFG_W      = 11;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;

    // Default store depth and the reset value of the element count register.
    localparam int              MAX_ELEMENTS_DEF = 1024;
    localparam logic [CFG_W-1:0] CFG_RESET       = 11'd1024;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_SHIFT,
        ST_DONE
    } rpd_state_t;

endpackage : rpd_pkg

`default_nettype wire

// ===== rtl/core/random_permutation_drawer.sv =====
`default_nettype none

// Channel  Direction  Payload (lowest bit first)
// -------  ---------  ---------------------------------------------------------
// s_*      in         tdata: random_word[30:0], zero[31]; tuser: begin_req
// m_*      out        tdata: element[9:0], zero[15:10]; tlast: last
// cfg_*    in         cfg_wdata: element_count[10:0], written when cfg_we is high
//
// A draw runs the bit-serial remainder unit over the random word, then moves
// each list entry after the drawn position one place down to fill its gap;
// a draw that starts a new permutation first refills the list memory,
// one entry per cycle on its write port.
// Reset clears the remaining count, so the first draw always refills the list.
// s_tready is high only between draws; a result waiting on m_* does not block
// a new transaction, but the next result is held until the previous is taken.
module random_permutation_drawer
    import rpd_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Input stream: tdata = random_word[30:0], bit 31 unused.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // tuser = begin_req.
    input  wire logic                 s_tuser,
    // Output stream: tdata = element[9:0], bits 15:10 zero.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast,
    // Configuration: element_count.
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int REM_W  = CNT_W + 1;
    localparam int BIT_W  = $clog2(WORD_W);

    rpd_state_t          state_reg, state_next;
    logic [CFG_W-1:0]    ec_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    n_eff;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [REM_W-1:0]    rem_shift;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [ELEM_W-1:0]   val_reg, val_next;
    logic                out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0]   out_elem_reg;
    logic                out_last_reg;
    logic                out_load;

    // List memory, one write and one read port.
    logic [ELEM_W-1:0]   mem [MAX_ELEMENTS];
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ELEM_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [ELEM_W-1:0]   mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    // Permutation length after clamping the register to 1..MAX_ELEMENTS.
    always_comb
    begin
        if (ec_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(ec_reg) > 32'(MAX_ELEMENTS))
        begin
            n_eff = CNT_W'(MAX_ELEMENTS);
        end
        else
        begin
            n_eff = CNT_W'(ec_reg);
        end
    end

    // One restoring step of the remainder: bring in the next word bit.
    assign rem_shift = {rem_reg[CNT_W-1:0], word_reg[WORD_W-1]};

    // Sequencer: next state, datapath updates and memory control.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        word_next      = word_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        out_load       = 1'b0;
        s_tready       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = ELEM_W'(idx_reg);
        mem_raddr      = ptr_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                word_next = s_tdata[WORD_W-1:0];
                rem_next  = '0;
                bit_next  = BIT_W'(WORD_W - 1);
                idx_next  = '0;
                if (s_tvalid)
                begin
                    if (s_tuser || (cnt_reg == '0))
                    begin
                        cnt_next   = n_eff;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end

            ST_LOAD:
            begin
                // Refill the list with 0..n-1, one entry per cycle.
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = ELEM_W'(idx_reg);
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == ADDR_W'(cnt_reg - 1'b1))
                begin
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // Restoring remainder, one word bit per cycle, MSB first.
                word_next = {word_reg[WORD_W-2:0], 1'b0};
                if (rem_shift >= {1'b0, cnt_reg})
                begin
                    rem_next = rem_shift - {1'b0, cnt_reg};
                end
                else
                begin
                    rem_next = rem_shift;
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    pos_next   = rem_next[ADDR_W-1:0];
                    ptr_next   = CNT_W'(rem_next);
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // Read entry at ptr, then write it one place lower.
                if (pend_reg)
                begin
                    if (pend_addr_reg == pos_reg)
                    begin
                        val_next = mem_rdata_reg;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_addr_reg - 1'b1;
                        mem_wdata = mem_rdata_reg;
                    end
                end
                if (ptr_reg < cnt_reg)
                begin
                    mem_raddr      = ptr_reg[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[ADDR_W-1:0];
                    ptr_next       = ptr_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ec_reg        <= CFG_RESET;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            if (cfg_we)
            begin
                ec_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        rem_reg       <= rem_next;
        bit_reg       <= bit_next;
        idx_reg       <= idx_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        if (out_load)
        begin
            out_elem_reg <= val_reg;
            out_last_reg <= (cnt_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - ELEM_W){1'b0}}, out_elem_reg};
    assign m_tlast  = out_last_reg;

    // The remaining count never exceeds the list depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("remaining count exceeds list depth");

    // A remainder is only computed against a non-empty list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("remainder started with empty list");

    // The partial remainder stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < {1'b0, cnt_reg}))
        else $error("partial remainder out of range");

    // During the gap close, writes always land below the entry being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SHIFT) && mem_we && pend_next) |->
            (mem_waddr < mem_raddr))
        else $error("shift write overtakes read");

    // A result is only loaded while the output register is free or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwrites pending output");

endmodule : random_permutation_drawer

`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;
    import rpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The stall limit lies well above the longest draw, one that refills a full list and then shifts all of it.
    localparam int STALL_LIMIT = 20000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIST_AW = $clog2(MAX_ELEMENTS_DEF);

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
    } draw_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // Fields from bit 0: random_word[30:0], zero pad[31].
    logic [S_TDATA_W-1:0] s_tdata;
    // Fields from bit 0: begin_req.
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // Fields from bit 0: element[9:0], zero pad[15:10].
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_wdata;

    // Predictor state: the undrawn values, how many remain, and the count register.
    logic [ELEM_W-1:0]    undrawn [MAX_ELEMENTS_DEF];
    logic [CFG_W-1:0]     undrawn_left = '0;
    logic [CFG_W-1:0]     count_setting = CFG_RESET;

    draw_t                pending_draws [$];
    int                   mismatches = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   quiet_cycles = 0;

    random_permutation_drawer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Computes the element a draw produces and updates the list of undrawn values.
    function automatic draw_t predict_draw(input logic [WORD_W-1:0] word, input logic restart);
        draw_t                result;
        logic [CFG_W-1:0]     n;
        logic [LIST_AW-1:0]   pos;
        if (restart || undrawn_left == 0)
        begin
            n = count_setting;
            if (n == 0)
                n = CFG_W'(1);
            if (n > MAX_ELEMENTS_DEF)
                n = CFG_W'(MAX_ELEMENTS_DEF);
            for (int i = 0; i < n; i++)
                undrawn[i] = i[ELEM_W-1:0];
            undrawn_left = n;
        end
        pos = LIST_AW'(word % undrawn_left);
        result.element = undrawn[pos];
        for (int j = pos; j + 1 < undrawn_left; j++)
            undrawn[j] = undrawn[j + 1];
        undrawn_left = undrawn_left - 1'b1;
        result.last = (undrawn_left == 0);
        return result;
    endfunction

    // Presents one draw request and waits for the transaction.
    task automatic send_draw(input logic [WORD_W-1:0] word, input logic restart);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, word};
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
        pending_draws.push_back(predict_draw(word, restart));
    endtask

    // Writes the element count once every outstanding draw has come back.
    task automatic write_count(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_draws.size() != 0 || !s_tready)
            @(posedge clk);
        cfg_we        <= 1'b1;
        cfg_wdata     <= value;
        count_setting = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // The count after reset, with the smallest and the largest random word.
    task automatic test_default_count();
        send_draw('0, 1'b0);
        send_draw({WORD_W{1'b1}}, 1'b0);
    endtask

    // Zero acts as one, values above the store saturate, and the smallest real sizes.
    task automatic test_count_limits();
        write_count('0);
        send_draw({WORD_W{1'b1}}, 1'b1);
        send_draw('0, 1'b0);
        write_count({CFG_W{1'b1}});
        send_draw(WORD_W'(MAX_ELEMENTS_DEF - 1), 1'b1);
        write_count(CFG_W'(1));
        send_draw(WORD_W'(12345), 1'b1);
        write_count(CFG_W'(2));
        send_draw({WORD_W{1'b1}}, 1'b0);
        send_draw('0, 1'b0);
    endtask

    // A new count written mid-permutation only applies at the next refill.
    task automatic test_late_count_change();
        write_count(CFG_W'(4));
        send_draw(WORD_W'(1), 1'b1);
        send_draw(WORD_W'(6), 1'b0);
        write_count(CFG_W'(3));
        send_draw(WORD_W'(7), 1'b0);
        send_draw(WORD_W'(2), 1'b0);
        send_draw(WORD_W'(5), 1'b0);
        send_draw(WORD_W'(9), 1'b0);
        send_draw(WORD_W'(4), 1'b0);
    endtask

    // A restart request in the middle of a permutation starts over from a full list.
    task automatic test_restart_midway();
        write_count(CFG_W'(6));
        send_draw(WORD_W'(3), 1'b0);
        send_draw(WORD_W'(8), 1'b0);
        send_draw(WORD_W'(5), 1'b1);
        for (int k = 0; k < 5; k++)
            send_draw(WORD_W'($urandom), 1'b0);
    endtask

    // Mostly complete permutations of small sizes, a few large ones, sporadic restarts.
    task automatic test_random_draws(input int sender_pct, input int receiver_pct,
                                     input int target);
        int               sent;
        int               pick;
        int               run;
        int               eff;
        logic [CFG_W-1:0] n;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                n = CFG_W'($urandom_range(1, 16));
            else if (pick < 88)
                n = CFG_W'($urandom_range(17, 64));
            else if (pick < 95)
                n = CFG_W'($urandom_range(65, 400));
            else if (pick < 97)
                n = '0;
            else
                n = CFG_W'($urandom_range(MAX_ELEMENTS_DEF, (1 << CFG_W) - 1));
            write_count(n);
            eff = (n == 0) ? 1 : ((n > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : int'(n));
            run = (eff <= 64) ? $urandom_range(1, 3 * eff + 1) : $urandom_range(2, 6);
            if (run > target - sent)
                run = target - sent;
            for (int k = 0; k < run; k++)
            begin
                send_draw(WORD_W'($urandom), $urandom_range(0, 99) < 4);
                sent++;
            end
        end
    endtask

    // Result checking against the oldest predicted draw.
    always @(posedge clk)
    begin
        draw_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_draws.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("%0t: unexpected result tdata 0x%04h last %0b",
                             $time, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_draws.pop_front();
                if (m_tdata[ELEM_W-1:0] !== want.element || m_tlast !== want.last
                    || m_tdata[M_TDATA_W-1:ELEM_W] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display("%0t: expected element %0d last %0b, got tdata 0x%04h last %0b",
                                 $time, want.element, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    // The receiver stalls at random.
    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 28;
        recv_idle_pct = 52;
        test_default_count();
        test_count_limits();
        test_late_count_change();
        test_restart_midway();
        test_random_draws(28, 52, 180);
        test_random_draws(52, 28, 180);
        test_random_draws(0, 0, 180);

        // Drain the outstanding draws and give the block time to show stray results.
        s_tvalid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rpd_pkg.sv
rtl/core/random_permutation_drawer.sv
test/tb_top.sv
